[hw/rtl/indexed_min_heap_decrease_key_defines.svh]
// Assertion macros shared by the heap RTL files.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define IMH_ASSERT_IMP(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define IMH_ASSERT_NXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IMH_ASSERT_IMP(lbl, c, r, ante, cons, msg)
`define IMH_ASSERT_NXT(lbl, c, r, ante, cons, msg)
`endif
`endif

[hw/rtl/imhdk_pkg.sv]
// Shared types and constants of the indexed min-heap block.
`timescale 1ns / 1ps
package imhdk_pkg;

    localparam int KEY_BITS_DEF   = 12;
    localparam int HEAP_DEPTH_DEF = 4096;
    localparam int SCORE_BITS_DEF = 48;
    localparam int LV_BITS        = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // flag memory bit positions
    localparam int FLAG_KNOWN  = 0;
    localparam int FLAG_QUEUED = 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_LOOK,
        OP_INS_NEW,
        OP_DEC,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_PLACE,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_DN_RD,
        OP_DN_MOVE,
        OP_REC_RD,
        OP_OUT_REC,
        OP_OUT_STAT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t status;
        logic    zero_key;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       known;
        logic       queued;
        logic       dec_less;
        logic       full;
        logic       empty;
        logic       at_root;
        logic       up_less;
        logic       has_child;
        logic       dn_less;
        logic       clr_done;
    } dp_stat_t;

endpackage

[hw/rtl/imhdk_dp.sv]
// Datapath: heap, key-slot, record and flag memories with working registers.
`timescale 1ns / 1ps
`include "indexed_min_heap_decrease_key_defines.svh"
module imhdk_dp #(
    parameter int KEY_BITS   = imhdk_pkg::KEY_BITS_DEF,
    parameter int HEAP_DEPTH = imhdk_pkg::HEAP_DEPTH_DEF,
    parameter int SCORE_BITS = imhdk_pkg::SCORE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  imhdk_pkg::dp_cmd_t                   cmd,
    output imhdk_pkg::dp_stat_t                  stat,
    input  logic [1:0]                           in_req_type,
    input  logic [KEY_BITS-1:0]                  in_key,
    input  logic signed [SCORE_BITS-1:0]         in_score,
    input  logic signed [SCORE_BITS-1:0]         in_prio,
    input  logic signed [imhdk_pkg::LV_BITS-1:0] in_lv,
    output logic [KEY_BITS-1:0]                  out_key,
    output logic signed [SCORE_BITS-1:0]         out_score,
    output logic signed [SCORE_BITS-1:0]         out_prio,
    output logic signed [imhdk_pkg::LV_BITS-1:0] out_lv,
    output logic [1:0]                           out_status
);
    localparam int LVB       = imhdk_pkg::LV_BITS;
    localparam int SLOT_BITS = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_BITS  = SLOT_BITS + 2;
    localparam int KEY_SPACE = 1 << KEY_BITS;
    localparam int HEAP_W    = KEY_BITS + SCORE_BITS;
    localparam int REC_W     = 2 * SCORE_BITS + LVB;

    logic [HEAP_W-1:0]    heap_mem [HEAP_DEPTH];
    logic [SLOT_BITS-1:0] slot_mem [KEY_SPACE];
    logic [REC_W-1:0]     rec_mem  [KEY_SPACE];
    logic [1:0]           flag_mem [KEY_SPACE];

    logic [1:0]            r_type_reg;
    logic [KEY_BITS-1:0]   r_key_reg;
    logic [SCORE_BITS-1:0] r_score_reg;
    logic [SCORE_BITS-1:0] r_prio_reg;
    logic [LVB-1:0]        r_lv_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [KEY_BITS:0]     clr_reg;
    logic [SLOT_BITS-1:0]  i_reg;
    logic [KEY_BITS-1:0]   e_key_reg;
    logic [SCORE_BITS-1:0] e_prio_reg;
    logic [HEAP_W-1:0]     rd0_reg;
    logic [HEAP_W-1:0]     rd1_reg;
    logic [SLOT_BITS-1:0]  slot_rd_reg;
    logic [REC_W-1:0]      rec_rd_reg;
    logic [1:0]            flag_rd_reg;
    logic [KEY_BITS-1:0]   out_key_reg;
    logic [SCORE_BITS-1:0] out_score_reg;
    logic [SCORE_BITS-1:0] out_prio_reg;
    logic [LVB-1:0]        out_lv_reg;
    logic [1:0]            out_status_reg;

    // heap entries hold {priority, key}
    logic [KEY_BITS-1:0]   rd0_key, rd1_key;
    logic [SCORE_BITS-1:0] rd0_prio, rd1_prio, rec_prio;
    assign rd0_key  = rd0_reg[KEY_BITS-1:0];
    assign rd1_key  = rd1_reg[KEY_BITS-1:0];
    assign rd0_prio = rd0_reg[HEAP_W-1:KEY_BITS];
    assign rd1_prio = rd1_reg[HEAP_W-1:KEY_BITS];
    assign rec_prio = rec_rd_reg[2*SCORE_BITS-1:SCORE_BITS];

    logic [SLOT_BITS-1:0] parent;
    logic [IDX_BITS-1:0]  l_idx, r_idx, n_ext;
    logic                 has_right;
    logic [HEAP_W-1:0]    child;
    logic [SLOT_BITS-1:0] child_idx;

    assign parent    = (i_reg - SLOT_BITS'(1)) >> 1;
    assign l_idx     = (IDX_BITS'(i_reg) << 1) + IDX_BITS'(1);
    assign r_idx     = (IDX_BITS'(i_reg) << 1) + IDX_BITS'(2);
    assign n_ext     = IDX_BITS'(count_reg);
    assign has_right = (r_idx < n_ext);

    // right child wins a tie
    always_comb
    begin
        if (has_right && !($signed(rd0_prio) < $signed(rd1_prio)))
        begin
            child     = rd1_reg;
            child_idx = r_idx[SLOT_BITS-1:0];
        end
        else
        begin
            child     = rd0_reg;
            child_idx = l_idx[SLOT_BITS-1:0];
        end
    end

    assign stat.req_type  = r_type_reg;
    assign stat.known     = flag_rd_reg[imhdk_pkg::FLAG_KNOWN];
    assign stat.queued    = flag_rd_reg[imhdk_pkg::FLAG_QUEUED];
    assign stat.dec_less  = $signed(r_prio_reg) < $signed(rec_prio);
    assign stat.full      = (count_reg == CNT_BITS'(HEAP_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.at_root   = (i_reg == '0);
    assign stat.up_less   = $signed(e_prio_reg) < $signed(rd0_prio);
    assign stat.has_child = (l_idx < n_ext);
    assign stat.dn_less   = $signed(child[HEAP_W-1:KEY_BITS]) < $signed(e_prio_reg);
    assign stat.clr_done  = clr_reg[KEY_BITS];

    // write and read port steering
    logic                 heap_we, slot_we, rec_we, flag_we;
    logic [SLOT_BITS-1:0] heap_wa, heap_ra0, heap_ra1, slot_wd;
    logic [HEAP_W-1:0]    heap_wd;
    logic [KEY_BITS-1:0]  slot_wa, flag_wa;
    logic [1:0]           flag_wd;
    logic [REC_W-1:0]     rec_wd;

    assign rec_wd = {r_lv_reg, r_prio_reg, r_score_reg};

    always_comb
    begin
        heap_we  = 1'b0;
        heap_wa  = i_reg;
        heap_wd  = {e_prio_reg, e_key_reg};
        slot_we  = 1'b0;
        slot_wa  = e_key_reg;
        slot_wd  = i_reg;
        rec_we   = 1'b0;
        flag_we  = 1'b0;
        flag_wa  = r_key_reg;
        flag_wd  = 2'b11;
        heap_ra0 = parent;
        heap_ra1 = SLOT_BITS'(count_reg - CNT_BITS'(1));
        case (cmd.op)
            imhdk_pkg::OP_CLEAR:
            begin
                flag_we = 1'b1;
                flag_wa = clr_reg[KEY_BITS-1:0];
                flag_wd = 2'b00;
            end
            imhdk_pkg::OP_INS_NEW:
            begin
                rec_we  = 1'b1;
                flag_we = 1'b1;
            end
            imhdk_pkg::OP_DEC:
            begin
                rec_we = 1'b1;
            end
            imhdk_pkg::OP_UP_MOVE:
            begin
                heap_we = 1'b1;
                heap_wd = rd0_reg;
                slot_we = 1'b1;
                slot_wa = rd0_key;
            end
            imhdk_pkg::OP_PLACE:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            imhdk_pkg::OP_POP_RD:
            begin
                heap_ra0 = '0;
            end
            imhdk_pkg::OP_POP_TAKE:
            begin
                flag_we = 1'b1;
                flag_wa = rd0_key;
                flag_wd = 2'b01;
            end
            imhdk_pkg::OP_DN_RD:
            begin
                heap_ra0 = l_idx[SLOT_BITS-1:0];
                heap_ra1 = has_right ? r_idx[SLOT_BITS-1:0] : l_idx[SLOT_BITS-1:0];
            end
            imhdk_pkg::OP_DN_MOVE:
            begin
                heap_we = 1'b1;
                heap_wd = child;
                slot_we = 1'b1;
                slot_wa = child[KEY_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        if (rec_we)
            rec_mem[r_key_reg] <= rec_wd;
        if (flag_we)
            flag_mem[flag_wa] <= flag_wd;
        if (cmd.op == imhdk_pkg::OP_LOOK)
        begin
            flag_rd_reg <= flag_mem[r_key_reg];
            slot_rd_reg <= slot_mem[r_key_reg];
        end
        if (cmd.op == imhdk_pkg::OP_LOOK || cmd.op == imhdk_pkg::OP_REC_RD)
            rec_rd_reg <= rec_mem[r_key_reg];
        if (cmd.op == imhdk_pkg::OP_UP_RD || cmd.op == imhdk_pkg::OP_POP_RD
            || cmd.op == imhdk_pkg::OP_DN_RD)
        begin
            rd0_reg <= heap_mem[heap_ra0];
            rd1_reg <= heap_mem[heap_ra1];
        end
    end

    // working and output registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            imhdk_pkg::OP_CAPTURE:
            begin
                r_type_reg  <= in_req_type;
                r_key_reg   <= in_key;
                r_score_reg <= in_score;
                r_prio_reg  <= in_prio;
                r_lv_reg    <= in_lv;
            end
            imhdk_pkg::OP_INS_NEW:
            begin
                i_reg      <= SLOT_BITS'(count_reg);
                e_key_reg  <= r_key_reg;
                e_prio_reg <= r_prio_reg;
            end
            imhdk_pkg::OP_DEC:
            begin
                i_reg      <= slot_rd_reg;
                e_key_reg  <= r_key_reg;
                e_prio_reg <= r_prio_reg;
            end
            imhdk_pkg::OP_UP_MOVE:
                i_reg <= parent;
            imhdk_pkg::OP_POP_TAKE:
            begin
                r_key_reg  <= rd0_key;
                i_reg      <= '0;
                e_key_reg  <= rd1_key;
                e_prio_reg <= rd1_prio;
            end
            imhdk_pkg::OP_DN_MOVE:
                i_reg <= child_idx;
            imhdk_pkg::OP_OUT_REC:
            begin
                out_key_reg    <= r_key_reg;
                out_score_reg  <= rec_rd_reg[SCORE_BITS-1:0];
                out_prio_reg   <= rec_prio;
                out_lv_reg     <= rec_rd_reg[REC_W-1:2*SCORE_BITS];
                out_status_reg <= imhdk_pkg::ST_OK;
            end
            imhdk_pkg::OP_OUT_STAT:
            begin
                out_key_reg    <= cmd.zero_key ? '0 : r_key_reg;
                out_score_reg  <= '0;
                out_prio_reg   <= '0;
                out_lv_reg     <= '0;
                out_status_reg <= cmd.status;
            end
            default:
            begin
            end
        endcase
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                imhdk_pkg::OP_CLEAR:    clr_reg   <= clr_reg + (KEY_BITS+1)'(1);
                imhdk_pkg::OP_INS_NEW:  count_reg <= count_reg + CNT_BITS'(1);
                imhdk_pkg::OP_POP_TAKE: count_reg <= count_reg - CNT_BITS'(1);
                default:
                begin
                end
            endcase
        end
    end

    assign out_key    = out_key_reg;
    assign out_score  = out_score_reg;
    assign out_prio   = out_prio_reg;
    assign out_lv     = out_lv_reg;
    assign out_status = out_status_reg;

    `IMH_ASSERT_IMP(a_ins_not_full, clk, rst_n, cmd.op == imhdk_pkg::OP_INS_NEW, !stat.full, "insert into full heap")
    `IMH_ASSERT_NXT(a_pop_shrinks, clk, rst_n, cmd.op == imhdk_pkg::OP_POP_TAKE, count_reg == $past(count_reg) - CNT_BITS'(1), "pop did not shrink heap")
    `IMH_ASSERT_IMP(a_dn_rd_child, clk, rst_n, cmd.op == imhdk_pkg::OP_DN_RD, stat.has_child, "sift-down read without child")
endmodule

[hw/rtl/imhdk_ctrl.sv]
// Controller state machine sequencing the heap datapath.
`timescale 1ns / 1ps
`include "indexed_min_heap_decrease_key_defines.svh"
module imhdk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output imhdk_pkg::dp_cmd_t  cmd,
    input  imhdk_pkg::dp_stat_t stat
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_DECIDE, S_UP_CHK, S_UP_CMP, S_POP_TAKE,
        S_DN_CHK, S_DN_CMP, S_FINISH, S_REC_WAIT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = imhdk_pkg::OP_NONE;
        cmd.status   = imhdk_pkg::ST_OK;
        cmd.zero_key = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                    state_next = S_IDLE;
                else
                    cmd.op = imhdk_pkg::OP_CLEAR;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.op     = imhdk_pkg::OP_CAPTURE;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.op     = imhdk_pkg::OP_LOOK;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                case (stat.req_type)
                    imhdk_pkg::REQ_INSERT:
                    begin
                        if (stat.known)
                        begin
                            state_next = S_FINISH;
                            if (stat.dec_less)
                            begin
                                cmd.op = imhdk_pkg::OP_DEC;
                                if (stat.queued)
                                    state_next = S_UP_CHK;
                            end
                        end
                        else if (stat.full)
                        begin
                            cmd.op     = imhdk_pkg::OP_OUT_STAT;
                            cmd.status = imhdk_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = imhdk_pkg::OP_INS_NEW;
                            state_next = S_UP_CHK;
                        end
                    end
                    imhdk_pkg::REQ_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.op       = imhdk_pkg::OP_OUT_STAT;
                            cmd.status   = imhdk_pkg::ST_EMPTY;
                            cmd.zero_key = 1'b1;
                        end
                        else
                        begin
                            cmd.op     = imhdk_pkg::OP_POP_RD;
                            state_next = S_POP_TAKE;
                        end
                    end
                    imhdk_pkg::REQ_LOOKUP:
                    begin
                        if (stat.known)
                            cmd.op = imhdk_pkg::OP_OUT_REC;
                        else
                        begin
                            cmd.op     = imhdk_pkg::OP_OUT_STAT;
                            cmd.status = imhdk_pkg::ST_UNKNOWN;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    cmd.op     = imhdk_pkg::OP_PLACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = imhdk_pkg::OP_UP_RD;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_less)
                begin
                    cmd.op     = imhdk_pkg::OP_UP_MOVE;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    cmd.op     = imhdk_pkg::OP_PLACE;
                    state_next = S_FINISH;
                end
            end
            S_POP_TAKE:
            begin
                cmd.op     = imhdk_pkg::OP_POP_TAKE;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (stat.has_child)
                begin
                    cmd.op     = imhdk_pkg::OP_DN_RD;
                    state_next = S_DN_CMP;
                end
                else
                begin
                    cmd.op     = imhdk_pkg::OP_PLACE;
                    state_next = S_FINISH;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_less)
                begin
                    cmd.op     = imhdk_pkg::OP_DN_MOVE;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    cmd.op     = imhdk_pkg::OP_PLACE;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.req_type == imhdk_pkg::REQ_POP)
                begin
                    cmd.op     = imhdk_pkg::OP_REC_RD;
                    state_next = S_REC_WAIT;
                end
                else
                begin
                    cmd.op     = imhdk_pkg::OP_OUT_STAT;
                    state_next = S_OUT;
                end
            end
            S_REC_WAIT:
            begin
                cmd.op     = imhdk_pkg::OP_OUT_REC;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_OUT);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    `IMH_ASSERT_IMP(a_ready_no_out, clk, rst_n, in_ready_reg, !out_valid_reg, "ready while result pending")
    `IMH_ASSERT_NXT(a_out_to_idle, clk, rst_n, out_valid_reg && out_ready, in_ready_reg, "no return to idle after result")
    `IMH_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.op == imhdk_pkg::OP_POP_RD, !stat.empty, "pop read on empty heap")
endmodule

[hw/rtl/indexed_min_heap_decrease_key.sv]
// Top level of the indexed min-heap with insert-or-decrease-key.
//
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   node_key, path_score, priority_req, last_var req_type
// m_axis    out  out_key, out_score, out_priority, out_last_var status
//
// Lookup and rejected requests, and an insert of a known key that does not
// sift, need no heap memory access. An insert that sifts climbs the heap and
// a pop descends it, one level at a time; the time a request takes is set by
// this sift loop, one heap memory read and one compare-and-move per level.
// After reset a clearing pass sweeps all 2^KEY_BITS entries of the flag
// memory; no item is taken meanwhile. One item is in work at a time; a
// result is held on m_axis until taken and the next item is taken after that.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key #(
    parameter int KEY_BITS   = imhdk_pkg::KEY_BITS_DEF,
    parameter int HEAP_DEPTH = imhdk_pkg::HEAP_DEPTH_DEF,
    parameter int SCORE_BITS = imhdk_pkg::SCORE_BITS_DEF,
    localparam int DATA_W    = KEY_BITS + 2 * SCORE_BITS + imhdk_pkg::LV_BITS,
    localparam int TDATA_W   = ((DATA_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // node_key, path_score, priority_req, last_var, zero pad
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_key, out_score, out_priority, out_last_var, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]         m_axis_tuser
);
    localparam int LVB = imhdk_pkg::LV_BITS;

    imhdk_pkg::dp_cmd_t  cmd;
    imhdk_pkg::dp_stat_t stat;

    logic [KEY_BITS-1:0]   o_key;
    logic [SCORE_BITS-1:0] o_score, o_prio;
    logic [LVB-1:0]        o_lv;

    // sequence each item; hold the result until the sink takes it
    imhdk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // unpack the item fields straight into the datapath capture registers
    imhdk_dp #(
        .KEY_BITS   (KEY_BITS),
        .HEAP_DEPTH (HEAP_DEPTH),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_req_type (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_BITS-1:0]),
        .in_score    (s_axis_tdata[KEY_BITS+SCORE_BITS-1:KEY_BITS]),
        .in_prio     (s_axis_tdata[KEY_BITS+2*SCORE_BITS-1:KEY_BITS+SCORE_BITS]),
        .in_lv       (s_axis_tdata[DATA_W-1:KEY_BITS+2*SCORE_BITS]),
        .out_key     (o_key),
        .out_score   (o_score),
        .out_prio    (o_prio),
        .out_lv      (o_lv),
        .out_status  (m_axis_tuser)
    );

    // pack the result, zero fill up to whole bytes
    assign m_axis_tdata = TDATA_W'({o_lv, o_prio, o_score, o_key});
endmodule
